// ===== rtl/bpa_pkg.sv =====
package bpa_pkg;

  // page map storage geometry
  localparam int WORD_BITS = 64;
  localparam int DEF_NUM_PAGES = 4096;
  localparam logic [12:0] LIMIT_RESET = 13'd4096;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_MARK    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_WAIT,
    S_URD,
    S_UWR,
    S_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_item;
    logic scan_init1;
    logic scan_init2;
    logic rd_word;
    logic latch_word;
    logic step;
    logic upd_rd;
    logic upd_wr;
    logic upd_next;
    logic finish;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    op_t  op;
    logic at_end;
    logic word_ok;
    logic found;
    logic pass2;
    logic range_empty;
    logic last_word;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/bitmap_page_allocator.sv =====
// Bitmap next-fit page allocator.
// Input channel (in_valid / in_stall): operation, start_page, page_count.
// A transfer happens when in_valid is high and in_stall low; one item is
// worked on at a time and in_stall stays high until its result is loaded.
// Output channel (out_valid / out_stall): status, first_page, used_count,
// one result per item, held in an output register while out_stall is high.
// Config channel (cfg_valid / cfg_ready): page_limit, always ready.
// Allocate scans one page per cycle from the cursor, pausing while each
// 64-page word of the map memory is read, and on a hit rewrites the run
// word by word, reading and then writing each word. Release and mark-free
// read and rewrite each touched word in the same way. The single map
// memory port serialises these reads and writes.
// Reset marks every page used (per-word valid bits, no clearing pass),
// zeroes cursor and count and sets page_limit to 4096. A stalled output
// holds the finished result; the next item's result waits until it is taken.
module bitmap_page_allocator #(
  parameter int NUM_PAGES = bpa_pkg::DEF_NUM_PAGES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] page_limit,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [11:0] start_page,
  input  logic [12:0] page_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [11:0] first_page,
  output logic [12:0] used_count
);
  import bpa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  bpa_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  bpa_datapath #(.NUM_PAGES(NUM_PAGES)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_valid (cfg_valid && cfg_ready),
    .page_limit(page_limit),
    .operation (operation),
    .start_page(start_page),
    .page_count(page_count),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .first_page(first_page),
    .used_count(used_count)
  );

`ifndef SYNTHESIS
  // one item at a time: an accepted item blocks the input next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while busy");

  // a failed allocation reports page zero
  a_fail_first_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> first_page == 12'd0)
    else $error("failed allocation with nonzero page");

  // a new result is never loaded over one still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !cmd.finish)
    else $error("result overwritten");
`endif

endmodule

// ===== rtl/bpa_ram.sv =====
module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/bpa_ctrl.sv =====
module bpa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  bpa_pkg::sts_t sts,
  output bpa_pkg::cmd_t cmd
);
  import bpa_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (sts.op)
          OP_ALLOC: state_next = S_SCAN;
          OP_RELEASE, OP_MARK: state_next = sts.range_empty ? S_DONE : S_URD;
          default: state_next = S_DONE;
        endcase
      end
      S_SCAN: begin
        priority if (sts.at_end) begin
          if (sts.pass2) state_next = S_DONE;
        end else if (!sts.word_ok) begin
          state_next = S_WAIT;
        end else if (sts.found) begin
          state_next = S_URD;
        end
      end
      S_WAIT: state_next = S_SCAN;
      S_URD: state_next = S_UWR;
      S_UWR: state_next = sts.last_word ? S_DONE : S_URD;
      S_DONE: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load_item = in_valid;
      end
      S_DISPATCH: begin
        cmd.scan_init1 = (sts.op == OP_ALLOC);
      end
      S_SCAN: begin
        priority if (sts.at_end) begin
          cmd.scan_init2 = !sts.pass2;
        end else if (!sts.word_ok) begin
          cmd.rd_word = 1'b1;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_WAIT: cmd.latch_word = 1'b1;
      S_URD: cmd.upd_rd = 1'b1;
      S_UWR: begin
        cmd.upd_wr = 1'b1;
        cmd.upd_next = !sts.last_word;
      end
      S_DONE: cmd.finish = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/bpa_datapath.sv =====
module bpa_datapath #(
  parameter int NUM_PAGES = 4096
) (
  input  logic          clk,
  input  logic          rst,
  input  bpa_pkg::cmd_t cmd,
  output bpa_pkg::sts_t sts,
  input  logic          cfg_valid,
  input  logic [12:0]   page_limit,
  input  logic [1:0]    operation,
  input  logic [11:0]   start_page,
  input  logic [12:0]   page_count,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          status,
  output logic [11:0]   first_page,
  output logic [12:0]   used_count
);
  import bpa_pkg::*;

  localparam int PW  = $clog2(NUM_PAGES + 1);
  localparam int XW  = (PW > 13) ? PW : 13;
  localparam int OBW = $clog2(WORD_BITS);
  localparam int NW  = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW  = (NW > 1) ? $clog2(NW) : 1;

  logic [12:0]          limit_q;
  op_t                  op_q;
  logic [XW-1:0]        want;
  logic [PW-1:0]        cursor, pos, bound, run, total, first_q;
  logic [PW-1:0]        upd_lo, upd_hi;
  logic [AW-1:0]        upd_word;
  logic                 word_ok, pass2, ok, range_empty;
  logic [WORD_BITS-1:0] word_q;
  logic [NW-1:0]        row_valid;
  logic                 rvld_q;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid) begin
      limit_q <= page_limit;
    end
  end

  logic [PW-1:0] eff_limit;
  assign eff_limit = (XW'(limit_q) > XW'(NUM_PAGES)) ? PW'(NUM_PAGES) : PW'(limit_q);

  // free range of an incoming item
  logic [XW:0]   hi_sum;
  logic [PW-1:0] hi_clamp;
  logic          free_empty;
  assign hi_sum = (XW+1)'(start_page) + (XW+1)'(page_count);
  assign hi_clamp = (hi_sum > (XW+1)'(NUM_PAGES)) ? PW'(NUM_PAGES) : PW'(hi_sum);
  assign free_empty = (page_count == 13'd0) || (XW'(start_page) >= XW'(NUM_PAGES));

  // scan step
  logic [WORD_BITS-1:0] ram_q;
  logic [WORD_BITS-1:0] rd_word;
  logic [PW-1:0]        pos_inc, run_inc;
  logic                 bit_free, found;
  assign rd_word  = rvld_q ? ram_q : '1;
  assign pos_inc  = pos + PW'(1);
  assign run_inc  = run + PW'(1);
  assign bit_free = !word_q[OBW'(pos)];
  assign found    = bit_free && (XW'(run_inc) == want);

  // word merge for range update
  logic [WORD_BITS-1:0] lo_mask, hi_mask, mask, wr_word;
  logic [OBW-1:0]       hi_off;
  logic [AW-1:0]        last_word_addr;
  logic                 last_word;
  assign last_word_addr = AW'((upd_hi - PW'(1)) >> OBW);
  assign last_word = (upd_word == last_word_addr);
  assign hi_off = OBW'(upd_hi);
  assign lo_mask = (upd_word == AW'(upd_lo >> OBW)) ?
                   ({WORD_BITS{1'b1}} << OBW'(upd_lo)) : '1;
  assign hi_mask = (last_word && hi_off != '0) ? ~({WORD_BITS{1'b1}} << hi_off) : '1;
  assign mask = lo_mask & hi_mask;
  assign wr_word = (op_q == OP_ALLOC) ? (rd_word | mask) : (rd_word & ~mask);

  // page map memory
  logic [AW-1:0]        ram_addr;
  assign ram_addr = cmd.rd_word ? AW'(pos >> OBW) : upd_word;

  bpa_ram #(.WIDTH(WORD_BITS), .DEPTH(NW)) u_ram (
    .clk  (clk),
    .we   (cmd.upd_wr),
    .addr (ram_addr),
    .wdata(wr_word),
    .rdata(ram_q)
  );

  // row valid bits, unwritten rows read as all used
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.upd_wr) begin
      row_valid[upd_word] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_word || cmd.upd_rd) rvld_q <= row_valid[ram_addr];
  end

  // item, scan and update registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q        <= op_t'(operation);
      want        <= XW'(page_count);
      upd_lo      <= PW'(start_page);
      upd_hi      <= hi_clamp;
      upd_word    <= AW'(PW'(start_page) >> OBW);
      range_empty <= free_empty;
      ok          <= 1'b0;
      first_q     <= '0;
    end
    if (cmd.scan_init1) begin
      pos   <= cursor;
      bound <= eff_limit;
      run   <= '0;
      pass2 <= 1'b0;
    end
    if (cmd.scan_init2) begin
      pos   <= '0;
      bound <= cursor;
      run   <= '0;
      pass2 <= 1'b1;
    end
    if (cmd.latch_word) word_q <= rd_word;
    if (cmd.step) begin
      pos <= pos_inc;
      run <= bit_free ? run_inc : '0;
      if (found) begin
        ok       <= 1'b1;
        first_q  <= pos_inc - run_inc;
        upd_lo   <= pos_inc - run_inc;
        upd_hi   <= pos_inc;
        upd_word <= AW'((pos_inc - run_inc) >> OBW);
      end
    end
    if (cmd.upd_next) upd_word <= upd_word + AW'(1);
  end

  // word loaded flag
  always_ff @(posedge clk) begin
    if (rst) begin
      word_ok <= 1'b0;
    end else if (cmd.scan_init1 || cmd.scan_init2) begin
      word_ok <= 1'b0;
    end else if (cmd.latch_word) begin
      word_ok <= 1'b1;
    end else if (cmd.step && OBW'(pos) == '1) begin
      word_ok <= 1'b0;
    end
  end

  // cursor and used count
  logic [PW-1:0] room;
  assign room = PW'(NUM_PAGES) - total;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
      total  <= '0;
    end else begin
      if (cmd.step && found) cursor <= pos_inc;
      if (cmd.finish) begin
        if (op_q == OP_ALLOC && ok) begin
          total <= (want > XW'(room)) ? PW'(NUM_PAGES) : total + PW'(want);
        end else if (op_q == OP_RELEASE) begin
          total <= (want > XW'(total)) ? '0 : total - PW'(want);
        end
      end
    end
  end

  // output register
  logic [PW-1:0] total_fin;
  always_comb begin
    total_fin = total;
    if (op_q == OP_ALLOC && ok) begin
      total_fin = (want > XW'(room)) ? PW'(NUM_PAGES) : total + PW'(want);
    end else if (op_q == OP_RELEASE) begin
      total_fin = (want > XW'(total)) ? '0 : total - PW'(want);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status     <= (op_q == OP_ALLOC) && !ok;
      first_page <= ok ? 12'(first_q) : 12'd0;
      used_count <= 13'(total_fin);
    end
  end

  assign sts.op          = op_q;
  assign sts.at_end      = (pos >= bound);
  assign sts.word_ok     = word_ok;
  assign sts.found       = found;
  assign sts.pass2       = pass2;
  assign sts.range_empty = range_empty;
  assign sts.last_word   = last_word;
  assign sts.out_free    = !out_valid || !out_stall;

endmodule

// ===== sim/bitmap_page_allocator_tb.sv =====
`timescale 1ns / 100ps

module bitmap_page_allocator_tb;
  import bpa_pkg::*;

  localparam int PAGES = 4096;
  localparam longint CYCLE_LIMIT = 30_000_000;

  // expected result of one operation
  typedef struct {
    logic        status;
    logic [11:0] first_page;
    logic [12:0] used_count;
  } alloc_result_t;

  // page map model and result checking
  class page_scoreboard;
    bit            used_map [PAGES];
    int unsigned   cursor;
    int unsigned   total;
    int unsigned   limit;
    alloc_result_t pending_q[$];
    int            mismatches;

    function void reset_state();
      foreach (used_map[i]) used_map[i] = 1'b1;
      cursor = 0;
      total = 0;
      limit = 4096;
      pending_q.delete();
      mismatches = 0;
    endfunction

    function void set_limit(logic [12:0] v);
      limit = v;
    endfunction

    // one next-fit pass from the cursor up to bound
    function bit find_run(int unsigned want, int unsigned bound, output int unsigned first);
      int unsigned run;
      int unsigned here;
      run = 0;
      first = 0;
      while (cursor < bound) begin
        here = cursor;
        cursor++;
        if (!used_map[here]) begin
          run++;
          if (run == want) begin
            first = cursor - want;
            for (int unsigned i = first; i < cursor; i++) used_map[i] = 1'b1;
            return 1'b1;
          end
        end else begin
          run = 0;
        end
      end
      return 1'b0;
    endfunction

    function void free_range(int unsigned start, int unsigned cnt);
      for (int unsigned i = 0; i < cnt; i++) begin
        if (start + i >= PAGES) break;
        used_map[start + i] = 1'b0;
      end
    endfunction

    // note an accepted transfer and queue its expected result
    function void note_input(op_t op, logic [11:0] start, logic [12:0] cnt);
      alloc_result_t r;
      int unsigned lim;
      int unsigned prior;
      int unsigned f;
      bit ok;
      r.status = 1'b0;
      r.first_page = '0;
      case (op)
        OP_ALLOC: begin
          lim = (limit > PAGES) ? PAGES : limit;
          prior = cursor;
          ok = find_run(cnt, lim, f);
          if (!ok) begin
            cursor = 0;
            ok = find_run(cnt, prior, f);
          end
          if (ok) begin
            total = (cnt > PAGES - total) ? PAGES : total + cnt;
            r.first_page = f[11:0];
          end else begin
            r.status = 1'b1;
          end
        end
        OP_RELEASE: begin
          free_range(start, cnt);
          total = (cnt > total) ? 0 : total - cnt;
        end
        OP_MARK: free_range(start, cnt);
        default: ;
      endcase
      r.used_count = total[12:0];
      pending_q.push_back(r);
    endfunction

    // compare a result transfer with the oldest expectation
    function void check_result(logic st, logic [11:0] fp, logic [12:0] uc);
      alloc_result_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status=%0d first_page=%0d used_count=%0d", st, fp, uc);
        return;
      end
      e = pending_q.pop_front();
      if (st !== e.status || fp !== e.first_page || uc !== e.used_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected status=%0d first_page=%0d used_count=%0d, got %0d %0d %0d",
                   e.status, e.first_page, e.used_count, st, fp, uc);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [12:0] page_limit;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  operation;
  logic [11:0] start_page;
  logic [12:0] page_count;
  logic        out_valid;
  logic        out_stall;
  logic        status;
  logic [11:0] first_page;
  logic [12:0] used_count;

  page_scoreboard sb;
  longint cycles;
  int     stall_left;
  bit     stall_on;
  bit     stall_quiet;

  bitmap_page_allocator dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .page_limit(page_limit),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .start_page(start_page), .page_count(page_count),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .first_page(first_page), .used_count(used_count)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: stall in bursts, with quiet stretches
  always @(posedge clk) begin
    if (stall_left == 0) begin
      if ($urandom_range(0, 49) == 0) stall_quiet <= ~stall_quiet;
      stall_on <= ~stall_on;
      if (stall_quiet || stall_on) stall_left <= $urandom_range(1, 20);
      else stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 3);
      out_stall <= !stall_quiet && !stall_on;
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  // result transfers
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(status, first_page, used_count);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [12:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 13'($urandom_range(0, 16));
    if (r < 90) return 13'($urandom_range(17, 256));
    if (r < 97) return 13'($urandom_range(257, 4096));
    return 13'($urandom_range(4097, 8191));
  endfunction

  // one operation transfer, then an optional gap
  task automatic send_op(op_t op, logic [11:0] start, logic [12:0] cnt);
    int gap;
    in_valid <= 1'b1;
    operation <= op;
    start_page <= start;
    page_count <= cnt;
    do @(posedge clk); while (in_stall);
    sb.note_input(op, start, cnt);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_limit(logic [12:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    page_limit <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_limit(v);
  endtask

  task automatic random_op();
    int r;
    op_t op;
    r = $urandom_range(0, 99);
    if (r < 45) op = OP_ALLOC;
    else if (r < 72) op = OP_RELEASE;
    else if (r < 95) op = OP_MARK;
    else op = OP_NONE;
    send_op(op, 12'($urandom_range(0, 4095)), pick_count());
  endtask

  logic [12:0] limits [9] = '{13'd0, 13'd8191, 13'd300, 13'd64, 13'd1,
                              13'd4096, 13'd1000, 13'd130, 13'd4096};

  initial begin
    sb = new();
    sb.reset_state();
    cycles <= 0;
    stall_left <= 0;
    stall_on <= 1'b0;
    stall_quiet <= 1'b0;
    out_stall <= 1'b0;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    page_limit <= 13'd4096;
    in_valid <= 1'b0;
    operation <= OP_NONE;
    start_page <= '0;
    page_count <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: everything used at reset, zero length, edges of the map
    send_op(OP_ALLOC, 12'd0, 13'd1);
    send_op(OP_ALLOC, 12'd0, 13'd0);
    send_op(OP_NONE, 12'd4095, 13'd8191);
    send_op(OP_MARK, 12'd0, 13'd4096);
    send_op(OP_ALLOC, 12'd0, 13'd0);
    send_op(OP_ALLOC, 12'd0, 13'd4096);
    send_op(OP_ALLOC, 12'd0, 13'd1);
    send_op(OP_MARK, 12'd4095, 13'd8191);
    send_op(OP_ALLOC, 12'd0, 13'd1);
    send_op(OP_MARK, 12'd0, 13'd100);
    send_op(OP_ALLOC, 12'd0, 13'd4097);
    send_op(OP_ALLOC, 12'd0, 13'd50);
    send_op(OP_ALLOC, 12'd0, 13'd50);
    send_op(OP_RELEASE, 12'd4000, 13'd8191);
    send_op(OP_RELEASE, 12'd0, 13'd10);
    send_op(OP_ALLOC, 12'd0, 13'd5);
    send_op(OP_ALLOC, 12'd0, 13'd5);
    send_op(OP_ALLOC, 12'd0, 13'd1);
    send_op(OP_MARK, 12'd2048, 13'd2048);
    send_op(OP_ALLOC, 12'd0, 13'd2048);
    send_op(OP_MARK, 12'd0, 13'd4096);
    send_op(OP_ALLOC, 12'd0, 13'd4096);
    send_op(OP_NONE, 12'd0, 13'd0);

    // random phases over a range of limits
    foreach (limits[p]) begin
      in_valid <= 1'b0;
      write_limit(limits[p]);
      repeat (148) random_op();
    end
    in_valid <= 1'b0;

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
